>>> sv/quadratic_probe_hash_table_top_defines.svh
// Assertion macros for the quadratic probe hash table.
// Included by the top level; no other dependencies.
`ifndef QUADRATIC_PROBE_HASH_TABLE_TOP_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QPHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define QPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/qpht_pkg.sv
// Shared types and constants for the quadratic probe hash table.
// No dependencies; used by qpht_mod_add and the top level.
package qpht_pkg;

  localparam int TABLE_SIZE_DEF = 64;
  localparam int KEY_BYTES_DEF  = 8;

  localparam int MOD_W   = 7;
  localparam int SUM_W   = 11;
  localparam int WORD_W  = 64;
  localparam int IDX_W   = 6;
  localparam int STAT_W  = 3;
  localparam int HBIT_W  = 4;

  localparam logic [MOD_W-1:0] TABLE_SIZE_RESET = 7'd64;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_USED  = 2'd1;
  localparam logic [1:0] SLOT_GONE  = 2'd2;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_DELETE = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FOUND     = 3'd1,
    STAT_UPDATED   = 3'd2,
    STAT_DELETED   = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_FULL      = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOME,
    ST_READ,
    ST_CHECK,
    ST_STEP_SQ,
    ST_STEP_SLOT,
    ST_STEP_ODD,
    ST_RESULT
  } fsm_t;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] name;
    logic [WORD_W-1:0] history;
    logic [WORD_W-1:0] treatment;
  } record_t;

endpackage

>>> sv/qpht_mod_add.sv
// Modular adder shared by hashing and probe stepping: (a + b + cin) mod n.
// Needs a, b < n; depends on qpht_pkg.
module qpht_mod_add
  import qpht_pkg::*;
(
  input  logic [MOD_W-1:0] a,
  input  logic [MOD_W-1:0] b,
  input  logic             cin,
  input  logic [MOD_W-1:0] n,
  output logic [MOD_W-1:0] y
);

  logic [MOD_W:0] total;

  always_comb begin
    total = {1'b0, a} + {1'b0, b} + {{MOD_W{1'b0}}, cin};
    if (total >= {1'b0, n}) begin
      y = MOD_W'(total - {1'b0, n});
    end else begin
      y = total[MOD_W-1:0];
    end
  end

endmodule

>>> sv/quadratic_probe_hash_table_top.sv
// Open-addressed hash table with quadratic probing, insert, search, update and delete.
// After reset a clearing pass marks every slot empty; no transaction is taken meanwhile,
// but table_size writes are. One request is handled at a time: the key is first hashed,
// then the first probe takes a registered read of the slot memories and the compare; each
// further probe uses one modular add unit three times per step, then the read and the
// compare, and the result is then loaded into the output register. The next request can be
// taken once that result is loaded. A finished result waits in the output register while
// the next request is taken; the block holds a later result back until that register has
// been emptied.
`include "quadratic_probe_hash_table_top_defines.svh"

module quadratic_probe_hash_table_top
  import qpht_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int KEY_BYTES  = KEY_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0], key[65:2], new_key[129:66], name_word[193:130],
  // history_word[257:194], treatment_word[321:258], zero[327:322]
  input  logic [327:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], slot_index[8:3], key_out[72:9], name_out[136:73],
  // history_out[200:137], treatment_out[264:201], zero[271:265]
  output logic [271:0] m_axis_tdata
);

  localparam int AW = $clog2(TABLE_SIZE);
  localparam logic [WORD_W-1:0] KEY_MASK =
    (KEY_BYTES >= 8) ? {WORD_W{1'b1}} : ((WORD_W'(1) << (8 * KEY_BYTES)) - WORD_W'(1));
  localparam logic [MOD_W-1:0] N_CAP = (TABLE_SIZE > 127) ? 7'd127 : MOD_W'(TABLE_SIZE);

  fsm_t state, state_next;

  logic [MOD_W-1:0]  table_size;
  logic [MOD_W-1:0]  n;
  logic [MOD_W-1:0]  one_mod, two_mod;

  logic [AW-1:0]     clr_addr;
  req_t              req;
  logic [WORD_W-1:0] key_r, new_key_r, name_r, history_r, treatment_r;
  logic [SUM_W-1:0]  sum_r;
  logic [HBIT_W-1:0] hbit;
  logic [MOD_W-1:0]  slot, sq, odd, probe;
  logic              hit;

  logic [1:0]        state_mem [TABLE_SIZE];
  record_t           rec_mem [TABLE_SIZE];
  logic [1:0]        rd_state;
  record_t           rd_rec;

  logic              st_we, rec_we, match;
  logic [AW-1:0]     st_waddr;
  logic [1:0]        st_wdata;
  record_t           rec_wdata;

  logic [MOD_W-1:0]  ma_a, ma_b, ma_y;
  logic              ma_cin;

  logic [WORD_W-1:0] in_key;
  logic [SUM_W-1:0]  byte_sum;

  logic [STAT_W-1:0] out_status;
  logic [IDX_W-1:0]  out_slot;
  record_t           out_rec;

  always_comb begin
    if (table_size == '0) begin
      n = MOD_W'(1);
    end else if (table_size > N_CAP) begin
      n = N_CAP;
    end else begin
      n = table_size;
    end
    one_mod = (n == MOD_W'(1)) ? '0 : MOD_W'(1);
    two_mod = (n <= MOD_W'(2)) ? '0 : MOD_W'(2);
  end

  always_comb begin
    in_key   = s_axis_tdata[65:2] & KEY_MASK;
    byte_sum = '0;
    for (int b = 0; b < 8; b++) begin
      byte_sum = byte_sum + SUM_W'(in_key[8*b +: 8]);
    end
  end

  always_comb begin
    ma_a   = slot;
    ma_b   = slot;
    ma_cin = 1'b0;
    unique case (state)
      ST_HOME: begin
        ma_a   = slot;
        ma_b   = slot;
        ma_cin = sum_r[hbit];
      end
      ST_STEP_SQ: begin
        ma_a = sq;
        ma_b = odd;
      end
      ST_STEP_SLOT: begin
        ma_a = slot;
        ma_b = sq;
      end
      ST_STEP_ODD: begin
        ma_a = odd;
        ma_b = two_mod;
      end
      default: begin
        ma_cin = 1'b0;
      end
    endcase
  end

  qpht_mod_add u_mod_add (
    .a   (ma_a),
    .b   (ma_b),
    .cin (ma_cin),
    .n   (n),
    .y   (ma_y)
  );

  always_comb begin
    if (req == REQ_INSERT) begin
      match = (rd_state != SLOT_USED);
    end else begin
      match = (rd_state == SLOT_USED) && (rd_rec.key == key_r);
    end
  end

  always_comb begin
    state_next = state;
    st_we      = 1'b0;
    st_waddr   = AW'(slot);
    st_wdata   = SLOT_USED;
    rec_we     = 1'b0;
    rec_wdata  = '{key: key_r, name: name_r, history: history_r, treatment: treatment_r};
    unique case (state)
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_addr;
        st_wdata = SLOT_EMPTY;
        if (clr_addr == AW'(TABLE_SIZE - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = ST_HOME;
        end
      end
      ST_HOME: begin
        if (hbit == '0) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (match) begin
          state_next = ST_RESULT;
          unique case (req)
            REQ_INSERT: begin
              st_we  = 1'b1;
              rec_we = 1'b1;
            end
            REQ_UPDATE: begin
              rec_we        = 1'b1;
              rec_wdata.key = new_key_r;
            end
            REQ_DELETE: begin
              st_we    = 1'b1;
              st_wdata = SLOT_GONE;
            end
            default: begin
              st_we = 1'b0;
            end
          endcase
        end else if ({1'b0, probe} + 8'd1 >= {1'b0, n}) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_STEP_SQ;
        end
      end
      ST_STEP_SQ: begin
        state_next = ST_STEP_SLOT;
      end
      ST_STEP_SLOT: begin
        state_next = ST_STEP_ODD;
      end
      ST_STEP_ODD: begin
        state_next = ST_READ;
      end
      ST_RESULT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= TABLE_SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      state_mem[st_waddr] <= st_wdata;
    end
    if (state == ST_READ) begin
      rd_state <= state_mem[AW'(slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (rec_we) begin
      rec_mem[AW'(slot)] <= rec_wdata;
    end
    if (state == ST_READ) begin
      rd_rec <= rec_mem[AW'(slot)];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          req         <= req_t'(s_axis_tdata[1:0]);
          key_r       <= in_key;
          new_key_r   <= s_axis_tdata[129:66] & KEY_MASK;
          name_r      <= s_axis_tdata[193:130];
          history_r   <= s_axis_tdata[257:194];
          treatment_r <= s_axis_tdata[321:258];
          sum_r       <= byte_sum;
          hbit        <= HBIT_W'(SUM_W - 1);
          slot        <= '0;
        end
      end
      ST_HOME: begin
        slot <= ma_y;
        hbit <= hbit - HBIT_W'(1);
        sq   <= '0;
        odd  <= one_mod;
        probe <= '0;
      end
      ST_CHECK: begin
        hit <= match;
      end
      ST_STEP_SQ: begin
        sq <= ma_y;
      end
      ST_STEP_SLOT: begin
        slot <= ma_y;
      end
      ST_STEP_ODD: begin
        odd   <= ma_y;
        probe <= probe + MOD_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (hit) begin
      out_status = STAT_W'(req);
      out_slot   = slot[IDX_W-1:0];
      out_rec    = rd_rec;
      if (req == REQ_INSERT || req == REQ_UPDATE) begin
        out_rec.key       = (req == REQ_UPDATE) ? new_key_r : key_r;
        out_rec.name      = name_r;
        out_rec.history   = history_r;
        out_rec.treatment = treatment_r;
      end
    end else begin
      out_status = (req == REQ_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
      out_slot   = '0;
      out_rec    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_RESULT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RESULT && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {7'd0, out_rec.treatment, out_rec.history, out_rec.name,
                       out_rec.key, out_slot, out_status};
    end
  end

  assign s_axis_tready = (state == ST_IDLE);

  `QPHT_ASSERT_NEXT(a_accept_starts_hash, clk, rst, s_axis_tvalid && s_axis_tready,
    state == ST_HOME, "accepted request did not start hashing")
  `QPHT_ASSERT_NOW(a_probe_in_range, clk, rst, state == ST_CHECK,
    probe < n && slot < n, "probe count or slot beyond table size in use")
  `QPHT_ASSERT_NOW(a_result_from_sequencer, clk, rst, $rose(m_axis_tvalid),
    $past(state) == ST_RESULT, "result appeared without a finished request")

endmodule
